@@ design/lr_pkg.sv @@
// Shared constants for the line rasterizer.
package lr_pkg;

  // Width of each coordinate field on the stream ports.
  localparam int FIELD_W = 6;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEFAULT  = 6;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

endpackage

@@ design/line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer.
//
//  channel   | direction | tdata (low bit up)                          | side band
//  s_axis    | in        | start_x, start_y, end_x, end_y (6 b each)   | -
//  m_axis    | out       | pixel_x, pixel_y (6 b each), 4 b zero       | tlast = last_pixel
//
// A segment of N pixels (N = major extent + 1, at most 2^COORD_BITS) occupies the
// pixel walker from the load of its command to its last pixel; no new command loads sooner.
// The classifier takes a segment per cycle while the command queue has room.
// Reset is synchronous and clears only the queue and walker control state.
// A stall on m_axis holds the walker; the queue keeps s_axis open meanwhile until it is full.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, zero fill
  output logic                   m_axis_tlast    // last_pixel
);

  localparam int CMD_W = 4 * COORD_BITS + 2;

  logic [CMD_W-1:0]   front_cmd, queue_cmd;
  logic               queue_valid, walk_ready;
  logic [FIELD_W-1:0] pixel_x, pixel_y;

  // Classify each incoming segment.
  lr_front #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CMD_W)
  ) u_front (
    .start_x(s_axis_tdata[FIELD_W-1:0]),
    .start_y(s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .end_x  (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
    .end_y  (s_axis_tdata[4*FIELD_W-1:3*FIELD_W]),
    .cmd    (front_cmd)
  );

  // Command queue between classifier and walker.
  lr_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(s_axis_tvalid),
    .push_ready(s_axis_tready),
    .push_data (front_cmd),
    .pop_valid (queue_valid),
    .pop_ready (walk_ready),
    .pop_data  (queue_cmd)
  );

  // Emit the pixels.
  lr_walk #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CMD_W)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(queue_valid),
    .cmd_ready(walk_ready),
    .cmd      (queue_cmd),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_x    (pixel_x),
    .out_y    (pixel_y),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 2 * FIELD_W)'(0), pixel_y, pixel_x};

endmodule

@@ design/lr_front.sv @@
// Segment classifier: finds the major axis, orders the endpoints and packs a command.
module lr_front
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int CMD_W      = 4 * COORD_BITS + 2
) (
  input  logic [FIELD_W-1:0] start_x,
  input  logic [FIELD_W-1:0] start_y,
  input  logic [FIELD_W-1:0] end_x,
  input  logic [FIELD_W-1:0] end_y,
  // Command fields from the lowest bit up: steep, step_neg, major_lo, major_hi,
  // minor_start, minor_extent.
  output logic [CMD_W-1:0]   cmd
);

  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep;
  logic [COORD_BITS-1:0] maj_a, min_a, maj_b, min_b;
  logic [COORD_BITS-1:0] major_lo, major_hi, minor_start, minor_end, minor_extent;
  logic                  step_neg;

  // Only the low coordinate bits take part.
  assign ax = start_x[COORD_BITS-1:0];
  assign ay = start_y[COORD_BITS-1:0];
  assign bx = end_x[COORD_BITS-1:0];
  assign by = end_y[COORD_BITS-1:0];

  // Extents along each axis; a line is steep when the vertical extent is larger.
  assign adx   = (bx > ax) ? (bx - ax) : (ax - bx);
  assign ady   = (by > ay) ? (by - ay) : (ay - by);
  assign steep = ady > adx;

  // Map onto major and minor axes.
  assign maj_a = steep ? ay : ax;
  assign min_a = steep ? ax : ay;
  assign maj_b = steep ? by : bx;
  assign min_b = steep ? bx : by;

  // Walk from the lower to the higher major coordinate.
  always_comb begin
    if (maj_a > maj_b) begin
      major_lo    = maj_b;
      major_hi    = maj_a;
      minor_start = min_b;
      minor_end   = min_a;
    end else begin
      major_lo    = maj_a;
      major_hi    = maj_b;
      minor_start = min_a;
      minor_end   = min_b;
    end
  end

  assign minor_extent = steep ? adx : ady;
  assign step_neg     = !(minor_start < minor_end);

  assign cmd = {minor_extent, minor_start, major_hi, major_lo, step_neg, steep};

endmodule

@@ design/lr_queue.sv @@
// Small register queue that decouples the classifier from the pixel walker.
module lr_queue
  import lr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/lr_walk.sv @@
// Pixel walker: steps the major axis one pixel per unstalled cycle; doubled error term.
module lr_walk
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int CMD_W      = 4 * COORD_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [CMD_W-1:0]       cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_W-1:0]     out_x,
  output logic [FIELD_W-1:0]     out_y,
  output logic                   out_last
);

  localparam int C    = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 3;

  logic                    busy;
  logic                    steep, step_neg;
  logic [C-1:0]            major, major_hi, minor;
  logic signed [ERR_W-1:0] err, err_sub, dmaj2, dmin2;
  logic [C-1:0]            c_lo, c_hi, c_minor, c_dmin;
  logic                    load, step_en, out_free, at_end;
  logic [C-1:0]            minor_step;

  // Unpack the command.
  assign c_lo    = cmd[C+1:2];
  assign c_hi    = cmd[2*C+1:C+2];
  assign c_minor = cmd[3*C+1:2*C+2];
  assign c_dmin  = cmd[4*C+1:3*C+2];

  assign cmd_ready = !busy;
  assign load      = cmd_valid && !busy;
  assign out_free  = !out_valid || out_ready;
  assign step_en   = busy && out_free;
  assign at_end    = major == major_hi;

  assign err_sub    = err - dmin2;
  assign minor_step = step_neg ? (minor - 1'b1) : (minor + 1'b1);

  // Walk state, error term and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step_en) begin
        out_valid <= 1'b1;
        out_x     <= FIELD_W'(steep ? minor : major);
        out_y     <= FIELD_W'(steep ? major : minor);
        out_last  <= at_end;
        major     <= major + 1'b1;
        if (at_end) begin
          busy <= 1'b0;
        end
        if (err_sub < 0) begin
          minor <= minor_step;
          err   <= err_sub + dmaj2;
        end else begin
          err <= err_sub;
        end
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (load) begin
          busy     <= 1'b1;
          steep    <= cmd[0];
          step_neg <= cmd[1];
          major    <= c_lo;
          major_hi <= c_hi;
          minor    <= c_minor;
          err      <= ERR_W'(c_hi - c_lo);
          dmaj2    <= ERR_W'({1'b0, c_hi - c_lo, 1'b0});
          dmin2    <= ERR_W'({1'b0, c_dmin, 1'b0});
        end
      end
    end
  end

`ifndef SYNTHESIS
  // The final pixel of a segment ends the walk.
  assert property (@(posedge clk) disable iff (rst)
    step_en && at_end |=> !busy)
    else $error("walker stayed busy after the final pixel");

  // A pixel carries the last mark exactly when it closes the walk.
  assert property (@(posedge clk) disable iff (rst)
    step_en |=> (out_last == !busy))
    else $error("last mark disagrees with walker state");

  // The error term stays within its doubled range.
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (err >= 0) && (err <= dmaj2))
    else $error("error term out of range");
`endif

endmodule
